// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Both forms sample on the rising clock edge and are off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define OAGS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OAGS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/oags_pkg.sv =====
`timescale 1ns / 1ps

package oags_pkg;

    // Vector path: differences are 17 bits, scaled up by 2^20 before rotation.
    localparam int PRE_SHIFT  = 20;
    localparam int XY_W       = 40;
    // Angle accumulator with 30 fraction bits.
    localparam int ACC_FRAC   = 30;
    localparam int Z_W        = 34;
    // Square root: 33-bit radicand, one result bit per cell.
    localparam int SQ_W       = 34;
    localparam int SQRT_STEPS = 17;

    localparam int ATAN_LEN = 24;

    // atan(2^-i) with 30 fraction bits.
    localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128
    };

    // pi/2 with 30 fraction bits.
    localparam logic [31:0] HALF_PI = 32'd1686629713;

    typedef enum logic [1:0] {
        MODE_AVOID_LEFT  = 2'd0,
        MODE_AVOID_RIGHT = 2'd1,
        MODE_GOAL        = 2'd2
    } steer_mode_t;

    typedef struct packed {
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic        [15:0] near_limit;
        logic        [14:0] heading_tolerance;
        logic        [14:0] arrive_margin;
    } cfg_t;

    // Values that ride along the cell row untouched.
    typedef struct packed {
        steer_mode_t        mode;
        logic               arrived;
        logic               zero;
        logic signed [15:0] heading;
        logic signed [15:0] avoid_turn;
        logic        [14:0] avoid_speed;
    } side_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic        [SQ_W-1:0] rem;
        logic        [SQ_W-1:0] root;
        side_t                  side;
    } cell_t;

endpackage

// ===== hw/rtl/oags_front.sv =====
`timescale 1ns / 1ps

module oags_front import oags_pkg::*; #(
    parameter int FRACTION_BITS = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic        [15:0] left_clearance,
    input  logic        [15:0] right_clearance,
    input  logic signed [15:0] pose_x,
    input  logic signed [15:0] pose_y,
    input  logic signed [15:0] heading,
    input  cfg_t               cfg,
    output logic               out_valid,
    output cell_t              out_cell
);

    localparam int AV_W = (FRACTION_BITS + 3 > 18) ? FRACTION_BITS + 3 : 18;
    localparam logic signed [AV_W-1:0] TWO =
        {{(AV_W-FRACTION_BITS-2){1'b0}}, 2'b10, {FRACTION_BITS{1'b0}}};
    localparam logic signed [AV_W-1:0] TURN_MAX = AV_W'(32767);
    localparam logic signed [AV_W-1:0] TURN_MIN = -(AV_W'(32768));

    // Stage A: differences, avoidance decision and arrival test.
    logic               a_valid_reg;
    logic signed [16:0] a_dx_reg, a_dx_next;
    logic signed [16:0] a_dy_reg, a_dy_next;
    side_t              a_side_reg, a_side_next;

    logic                   avoid_left, avoid_right;
    logic signed [AV_W-1:0] left_ext, right_ext, av_diff;
    logic signed [16:0]     gx_lim, gy_lim, px_ext, py_ext;

    always_comb begin
        a_dx_next   = {cfg.goal_x[15], cfg.goal_x} - {pose_x[15], pose_x};
        a_dy_next   = {cfg.goal_y[15], cfg.goal_y} - {pose_y[15], pose_y};
        avoid_left  = left_clearance < cfg.near_limit;
        avoid_right = right_clearance < cfg.near_limit;
        left_ext    = {{(AV_W-16){1'b0}}, left_clearance};
        right_ext   = {{(AV_W-16){1'b0}}, right_clearance};
        av_diff     = avoid_left ? (left_ext - TWO) : (TWO - right_ext);

        a_side_next = '0;
        if (avoid_left) begin
            a_side_next.mode = MODE_AVOID_LEFT;
        end else if (avoid_right) begin
            a_side_next.mode = MODE_AVOID_RIGHT;
        end else begin
            a_side_next.mode = MODE_GOAL;
        end
        if (av_diff > TURN_MAX) begin
            a_side_next.avoid_turn = 16'sh7fff;
        end else if (av_diff < TURN_MIN) begin
            a_side_next.avoid_turn = 16'sh8000;
        end else begin
            a_side_next.avoid_turn = av_diff[15:0];
        end
        a_side_next.avoid_speed = avoid_left ? left_clearance[15:1] : right_clearance[15:1];
        a_side_next.heading     = heading;

        gx_lim = {cfg.goal_x[15], cfg.goal_x} - {2'b00, cfg.arrive_margin};
        gy_lim = {cfg.goal_y[15], cfg.goal_y} - {2'b00, cfg.arrive_margin};
        px_ext = {pose_x[15], pose_x};
        py_ext = {pose_y[15], pose_y};
        a_side_next.arrived = (px_ext >= gx_lim) && (py_ext >= gy_lim);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
        if (en) begin
            a_dx_reg   <= a_dx_next;
            a_dy_reg   <= a_dy_next;
            a_side_reg <= a_side_next;
        end
    end

    // Stage B: quadrant fold for the rotation, squares for the distance.
    logic                   b_valid_reg;
    logic signed [XY_W-1:0] b_x_reg, b_x_next;
    logic signed [XY_W-1:0] b_y_reg, b_y_next;
    logic signed [Z_W-1:0]  b_z_reg, b_z_next;
    logic        [31:0]     b_sqx_reg, b_sqy_reg;
    side_t                  b_side_reg, b_side_next;

    logic signed [16:0] xr, yr;
    logic signed [33:0] sqx, sqy;

    always_comb begin
        if (a_dx_reg[16]) begin
            if (!a_dy_reg[16]) begin
                xr       = a_dy_reg;
                yr       = -a_dx_reg;
                b_z_next = $signed({{(Z_W-32){1'b0}}, HALF_PI});
            end else begin
                xr       = -a_dy_reg;
                yr       = a_dx_reg;
                b_z_next = -$signed({{(Z_W-32){1'b0}}, HALF_PI});
            end
        end else begin
            xr       = a_dx_reg;
            yr       = a_dy_reg;
            b_z_next = '0;
        end
        b_x_next = {{(XY_W-17-PRE_SHIFT){xr[16]}}, xr, {PRE_SHIFT{1'b0}}};
        b_y_next = {{(XY_W-17-PRE_SHIFT){yr[16]}}, yr, {PRE_SHIFT{1'b0}}};
        sqx      = 34'(a_dx_reg) * 34'(a_dx_reg);
        sqy      = 34'(a_dy_reg) * 34'(a_dy_reg);

        b_side_next      = a_side_reg;
        b_side_next.zero = (a_dx_reg == '0) && (a_dy_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
        if (en) begin
            b_x_reg    <= b_x_next;
            b_y_reg    <= b_y_next;
            b_z_reg    <= b_z_next;
            b_sqx_reg  <= sqx[31:0];
            b_sqy_reg  <= sqy[31:0];
            b_side_reg <= b_side_next;
        end
    end

    // Stage C: radicand sum, handed to the first cell.
    logic        c_valid_reg;
    cell_t       c_cell_reg, c_cell_next;
    logic [32:0] sq_sum;

    always_comb begin
        sq_sum           = {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};
        c_cell_next.x    = b_x_reg;
        c_cell_next.y    = b_y_reg;
        c_cell_next.z    = b_z_reg;
        c_cell_next.rem  = {{(SQ_W-33){1'b0}}, sq_sum};
        c_cell_next.root = '0;
        c_cell_next.side = b_side_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
        if (en) begin
            c_cell_reg <= c_cell_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_cell  = c_cell_reg;

endmodule

// ===== hw/rtl/oags_cell.sv =====
`timescale 1ns / 1ps

module oags_cell import oags_pkg::*; #(
    parameter int INDEX         = 0,
    parameter int CORDIC_STAGES = 16
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  cell_t in_cell,
    output logic  out_valid,
    output cell_t out_cell
);

    // One rotation of the vectoring loop and one bit of the square root.
    localparam bit ROTATE    = (INDEX < CORDIC_STAGES) && (INDEX < ATAN_LEN);
    localparam bit ROOT_STEP = INDEX < SQRT_STEPS;
    localparam int SQ_SH     = ROOT_STEP ? 2 * (SQRT_STEPS - 1 - INDEX) : 0;
    localparam int TAB_IDX   = (INDEX < ATAN_LEN) ? INDEX : 0;
    localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(64'd1 << SQ_SH);
    localparam logic signed [Z_W-1:0] ANGLE_STEP =
        $signed({{(Z_W-30){1'b0}}, ATAN_TAB[TAB_IDX]});

    logic signed [XY_W-1:0] x_in, y_in, x_sh, y_sh;
    logic signed [Z_W-1:0]  z_in;
    logic        [SQ_W-1:0] trial;
    cell_t                  cell_next;
    logic                   valid_reg;
    cell_t                  cell_reg;

    always_comb begin
        cell_next = in_cell;
        x_in      = in_cell.x;
        y_in      = in_cell.y;
        z_in      = in_cell.z;
        x_sh      = x_in >>> INDEX;
        y_sh      = y_in >>> INDEX;
        trial     = in_cell.root + SQ_BIT;
        if (ROTATE) begin
            if (!y_in[XY_W-1]) begin
                cell_next.x = x_in + y_sh;
                cell_next.y = y_in - x_sh;
                cell_next.z = z_in + ANGLE_STEP;
            end else begin
                cell_next.x = x_in - y_sh;
                cell_next.y = y_in + x_sh;
                cell_next.z = z_in - ANGLE_STEP;
            end
        end
        if (ROOT_STEP) begin
            if (in_cell.rem >= trial) begin
                cell_next.rem  = in_cell.rem - trial;
                cell_next.root = (in_cell.root >> 1) + SQ_BIT;
            end else begin
                cell_next.root = in_cell.root >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

// ===== hw/rtl/oags_back.sv =====
`timescale 1ns / 1ps

module oags_back import oags_pkg::*; #(
    parameter int FRACTION_BITS = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  cell_t              in_cell,
    input  logic        [14:0] heading_tolerance,
    output logic               out_valid,
    output logic        [16:0] speed_cmd,
    output logic signed [15:0] turn_cmd,
    output steer_mode_t        steer_mode,
    output logic               arrived
);

    localparam int RND_SH = ACC_FRAC - FRACTION_BITS;
    localparam int ANG_W  = FRACTION_BITS + 3;
    localparam int ERR_W  = ((ANG_W > 16) ? ANG_W : 16) + 1;
    localparam logic signed [Z_W-1:0]   RND_HALF = Z_W'(64'd1 << (RND_SH - 1));
    localparam logic signed [ERR_W-1:0] TURN_MAX = ERR_W'(32767);
    localparam logic signed [ERR_W-1:0] TURN_MIN = -(ERR_W'(32768));

    // Stage R: round the angle accumulator, halves upward.
    logic                    r_valid_reg;
    logic signed [ANG_W-1:0] r_angle_reg, r_angle_next;
    logic        [16:0]      r_root_reg;
    side_t                   r_side_reg;
    logic signed [Z_W-1:0]   rounded;

    always_comb begin
        rounded      = (in_cell.z + RND_HALF) >>> RND_SH;
        r_angle_next = in_cell.side.zero ? '0 : rounded[ANG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (en) begin
            r_valid_reg <= in_valid;
        end
        if (en) begin
            r_angle_reg <= r_angle_next;
            r_root_reg  <= in_cell.root[16:0];
            r_side_reg  <= in_cell.side;
        end
    end

    // Stage O: heading error, tolerance window, mode select.
    logic                    valid_reg;
    logic        [16:0]      speed_reg, speed_next;
    logic signed [15:0]      turn_reg, turn_next;
    steer_mode_t             mode_reg;
    logic                    arrived_reg;
    logic signed [ERR_W-1:0] err, tol_pos, tol_neg;
    logic                    in_tol;
    logic signed [15:0]      goal_turn;

    always_comb begin
        err = {{(ERR_W-ANG_W){r_angle_reg[ANG_W-1]}}, r_angle_reg}
            - {{(ERR_W-16){r_side_reg.heading[15]}}, r_side_reg.heading};
        tol_pos = {{(ERR_W-15){1'b0}}, heading_tolerance};
        tol_neg = -tol_pos;
        in_tol  = (err <= tol_pos) && (err >= tol_neg);
        if (err > TURN_MAX) begin
            goal_turn = 16'sh7fff;
        end else if (err < TURN_MIN) begin
            goal_turn = 16'sh8000;
        end else begin
            goal_turn = err[15:0];
        end
        // The root of two 16-bit squares stays below the 17-bit ceiling.
        case (r_side_reg.mode) inside
            MODE_AVOID_LEFT, MODE_AVOID_RIGHT: begin
                speed_next = {2'b00, r_side_reg.avoid_speed};
                turn_next  = r_side_reg.avoid_turn;
            end
            MODE_GOAL: begin
                speed_next = in_tol ? r_root_reg : '0;
                turn_next  = goal_turn;
            end
            default: begin
                speed_next = '0;
                turn_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= r_valid_reg;
        end
        if (en) begin
            speed_reg   <= speed_next;
            turn_reg    <= turn_next;
            mode_reg    <= r_side_reg.mode;
            arrived_reg <= r_side_reg.arrived;
        end
    end

    assign out_valid  = valid_reg;
    assign speed_cmd  = speed_reg;
    assign turn_cmd   = turn_reg;
    assign steer_mode = mode_reg;
    assign arrived    = arrived_reg;

endmodule

// ===== hw/rtl/obstacle_avoid_goal_steering_core.sv =====
// Path: front stages A, B and C, then the cell row, then back stages R and O; the
// length of the cell row sets the depth from an accepted request to its result.
// Throughput: one request per cycle while the output is not stalled; the row of cells advances together.
// Reset: aresetn is synchronous and active low; it empties the pipeline and loads the
// default goal (5.0, -3.5), near limit 0.5, heading tolerance 1 LSB, arrival margin 0.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module obstacle_avoid_goal_steering_core import oags_pkg::*; #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRACTION_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, low bit up: left_clearance[15:0], right_clearance[31:16],
    // pose_x[47:32], pose_y[63:48], heading[79:64].
    input  logic [79:0] s_tdata,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, low bit up: speed_cmd[16:0], turn_cmd[32:17], arrived[33],
    // zero fill [39:34].
    output logic [39:0] m_tdata,
    // m_tuser, low bit up: steer_mode[1:0].
    output logic [1:0]  m_tuser,
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The row carries both the angle rotations and the square root bits, so it
    // is as long as the longer of the two.
    localparam int NCELL = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

    localparam logic [2:0] REG_GOAL_X   = 3'd0;
    localparam logic [2:0] REG_GOAL_Y   = 3'd1;
    localparam logic [2:0] REG_NEAR     = 3'd2;
    localparam logic [2:0] REG_TOL      = 3'd3;
    localparam logic [2:0] REG_MARGIN   = 3'd4;

    // ------------------------------------------------------------------
    // Register file. A write lands in the access phase; pready never
    // drops, so no wait states are inserted.
    // ------------------------------------------------------------------
    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.goal_x            <= 16'sd20480;
            cfg_reg.goal_y            <= -16'sd14336;
            cfg_reg.near_limit        <= 16'd2048;
            cfg_reg.heading_tolerance <= 15'd1;
            cfg_reg.arrive_margin     <= 15'd0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GOAL_X: cfg_reg.goal_x            <= pwdata[15:0];
                REG_GOAL_Y: cfg_reg.goal_y            <= pwdata[15:0];
                REG_NEAR:   cfg_reg.near_limit        <= pwdata[15:0];
                REG_TOL:    cfg_reg.heading_tolerance <= pwdata[14:0];
                REG_MARGIN: cfg_reg.arrive_margin     <= pwdata[14:0];
                default: begin
                end
            endcase
        end
    end

    // Reads return the stored field, zero extended.
    always_comb begin
        unique case (reg_idx)
            REG_GOAL_X: prdata = {16'd0, cfg_reg.goal_x};
            REG_GOAL_Y: prdata = {16'd0, cfg_reg.goal_y};
            REG_NEAR:   prdata = {16'd0, cfg_reg.near_limit};
            REG_TOL:    prdata = {17'd0, cfg_reg.heading_tolerance};
            REG_MARGIN: prdata = {17'd0, cfg_reg.arrive_margin};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control. Every stage moves on the same enable, which drops only
    // while a finished result sits in the output register and the sink is
    // not taking it. The output register is the last stage, so a new
    // request is taken in the same cycle as the waiting result leaves.
    // ------------------------------------------------------------------
    logic pipe_en;

    assign pipe_en  = !m_tvalid || m_tready;
    assign s_tready = pipe_en;

    // ------------------------------------------------------------------
    // Front stages: goal differences, avoidance choice, arrival test,
    // quadrant fold and the squares of the differences.
    // ------------------------------------------------------------------
    cell_t            chain_cell [NCELL+1];
    logic [NCELL:0]   chain_valid;

    oags_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (pipe_en),
        .in_valid        (s_tvalid),
        .left_clearance  (s_tdata[15:0]),
        .right_clearance (s_tdata[31:16]),
        .pose_x          (s_tdata[47:32]),
        .pose_y          (s_tdata[63:48]),
        .heading         (s_tdata[79:64]),
        .cfg             (cfg_reg),
        .out_valid       (chain_valid[0]),
        .out_cell        (chain_cell[0])
    );

    // ------------------------------------------------------------------
    // Cell row. Cell i performs rotation i of the arctangent and settles
    // bit 16 - i of the distance; cells past either count pass that part
    // through unchanged.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        oags_cell #(
            .INDEX         (g),
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (chain_valid[g]),
            .in_cell   (chain_cell[g]),
            .out_valid (chain_valid[g+1]),
            .out_cell  (chain_cell[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Back stages: rounding of the angle, heading error, tolerance window
    // and the output register.
    // ------------------------------------------------------------------
    logic        [16:0] speed_cmd;
    logic signed [15:0] turn_cmd;
    steer_mode_t        steer_mode;
    logic               arrived;

    oags_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .en                (pipe_en),
        .in_valid          (chain_valid[NCELL]),
        .in_cell           (chain_cell[NCELL]),
        .heading_tolerance (cfg_reg.heading_tolerance),
        .out_valid         (m_tvalid),
        .speed_cmd         (speed_cmd),
        .turn_cmd          (turn_cmd),
        .steer_mode        (steer_mode),
        .arrived           (arrived)
    );

    assign m_tdata = {6'd0, arrived, turn_cmd, speed_cmd};
    assign m_tuser = steer_mode;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    // The request side only holds off while a result is stuck at the output.
    `OAGS_ASSERT_IMP(a_ready_only_on_stall, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "request side stalled without a blocked result")
    // A stalled row keeps its occupancy.
    `OAGS_ASSERT_NXT(a_row_holds, aclk, aresetn, !pipe_en, $stable(chain_valid), "cell row moved while stalled")
    // Avoidance speeds are half a 16-bit clearance.
    `OAGS_ASSERT_IMP(a_avoid_speed, aclk, aresetn, m_tvalid && (m_tuser != MODE_GOAL), m_tdata[16:15] == 2'b00, "avoidance speed out of range")

endmodule

// ===== dv/steer_regs_pkg.sv =====
`timescale 1ns / 1ps

package steer_regs_pkg;

    // Register indexes; each register sits at byte address 4 * index.
    typedef enum int {
        REG_GOAL_X        = 0,
        REG_GOAL_Y        = 1,
        REG_NEAR_LIMIT    = 2,
        REG_HEADING_TOL   = 3,
        REG_ARRIVE_MARGIN = 4
    } steer_reg_t;

    localparam int RESET_GOAL_X        = 20480;
    localparam int RESET_GOAL_Y        = -14336;
    localparam int RESET_NEAR_LIMIT    = 2048;
    localparam int RESET_HEADING_TOL   = 1;
    localparam int RESET_ARRIVE_MARGIN = 0;

endpackage

// ===== dv/steering_cmd_check.sv =====
`timescale 1ns / 1ps

module steering_cmd_check import oags_pkg::*; import steer_regs_pkg::*; #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRACTION_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          outstanding
);

    localparam longint QUARTER_TURN = 64'sd1686629713;

    typedef struct packed {
        logic [16:0] speed;
        logic [15:0] turn;
        logic [1:0]  mode;
        logic        arrived;
    } steer_cmd_t;

    steer_cmd_t expected_cmds[$];

    longint goal_x_c, goal_y_c, near_c, tol_c, margin_c;

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    // atan(2^-i) with 30 fraction bits.
    function automatic longint atan_step(int i);
        case (i)
            0:  return 843314857;
            1:  return 497837829;
            2:  return 263043837;
            3:  return 133525159;
            4:  return 67021687;
            5:  return 33543516;
            6:  return 16775851;
            7:  return 8388437;
            8:  return 4194283;
            9:  return 2097149;
            10: return 1048576;
            11: return 524288;
            12: return 262144;
            13: return 131072;
            14: return 65536;
            15: return 32768;
            16: return 16384;
            17: return 8192;
            18: return 4096;
            19: return 2048;
            20: return 1024;
            21: return 512;
            22: return 256;
            default: return 128;
        endcase
    endfunction

    function automatic longint goal_bearing(longint dy, longint dx);
        longint x, y, z, xs, ys, t;
        if (dx == 0 && dy == 0) return 0;
        x = dx * 64'sd1048576;
        y = dy * 64'sd1048576;
        z = 0;
        // Fold the left half plane into the right one first.
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = QUARTER_TURN;
            end else begin
                t = x; x = -y; y = t; z = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + atan_step(i);
            end else begin
                x = x - ys; y = y + xs; z = z - atan_step(i);
            end
        end
        return (z + (64'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
    endfunction

    function automatic longint floor_root(longint n);
        longint r, c;
        r = 0;
        for (int b = 17; b >= 0; b--) begin
            c = r | (64'sd1 <<< b);
            if (c * c <= n) r = c;
        end
        return r;
    endfunction

    function automatic steer_cmd_t predict_steering(logic [79:0] d);
        longint lc, rc, px, py, pa, dx, dy, err, turn, spd, two;
        steer_cmd_t c;
        lc  = longint'(d[15:0]);
        rc  = longint'(d[31:16]);
        px  = longint'($signed(d[47:32]));
        py  = longint'($signed(d[63:48]));
        pa  = longint'($signed(d[79:64]));
        two = 64'sd2 <<< FRACTION_BITS;
        if (lc < near_c) begin
            c.mode = MODE_AVOID_LEFT;
            turn   = lc - two;
            spd    = lc >>> 1;
        end else if (rc < near_c) begin
            c.mode = MODE_AVOID_RIGHT;
            turn   = two - rc;
            spd    = rc >>> 1;
        end else begin
            dx     = goal_x_c - px;
            dy     = goal_y_c - py;
            err    = goal_bearing(dy, dx) - pa;
            c.mode = MODE_GOAL;
            turn   = err;
            // The tolerance test sees the error before it is clipped.
            spd    = ((err < 0 ? -err : err) <= tol_c) ? floor_root(dx * dx + dy * dy) : 0;
        end
        if (spd > 131071) spd = 131071;
        if (turn > 32767) turn = 32767;
        if (turn < -32768) turn = -32768;
        c.speed   = spd[16:0];
        c.turn    = turn[15:0];
        c.arrived = (px >= goal_x_c - margin_c) && (py >= goal_y_c - margin_c);
        return c;
    endfunction

    always @(posedge aclk) begin
        steer_cmd_t want, got;
        if (!aresetn) begin
            goal_x_c = RESET_GOAL_X;
            goal_y_c = RESET_GOAL_Y;
            near_c   = RESET_NEAR_LIMIT;
            tol_c    = RESET_HEADING_TOL;
            margin_c = RESET_ARRIVE_MARGIN;
            expected_cmds.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (int'(paddr >> 2))
                    REG_GOAL_X:        goal_x_c = longint'($signed(pwdata[15:0]));
                    REG_GOAL_Y:        goal_y_c = longint'($signed(pwdata[15:0]));
                    REG_NEAR_LIMIT:    near_c   = longint'(pwdata[15:0]);
                    REG_HEADING_TOL:   tol_c    = longint'(pwdata[14:0]);
                    REG_ARRIVE_MARGIN: margin_c = longint'(pwdata[14:0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_cmds.push_back(predict_steering(s_tdata));
            if (m_tvalid && m_tready) begin
                got.speed   = m_tdata[16:0];
                got.turn    = m_tdata[32:17];
                got.arrived = m_tdata[33];
                got.mode    = m_tuser;
                if (expected_cmds.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with no request pending: %s %0d %0d %0d %0d",
                                 $realtime, "speed/turn/mode/arrived", got.speed,
                                 $signed(got.turn), got.mode, got.arrived);
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.speed !== want.speed || got.turn !== want.turn ||
                        got.mode !== want.mode || got.arrived !== want.arrived) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: steering mismatch: expected speed %0d turn %0d",
                                      " mode %0d arrived %0d, got speed %0d turn %0d",
                                      " mode %0d arrived %0d"},
                                     $realtime, want.speed, $signed(want.turn), want.mode,
                                     want.arrived, got.speed, $signed(got.turn), got.mode,
                                     got.arrived);
                    end
                end
            end
        end
        outstanding <= expected_cmds.size();
    end

endmodule

// ===== dv/tb_obstacle_avoid_goal_steering_core.sv =====
`timescale 1ns / 1ps

module tb_obstacle_avoid_goal_steering_core;

    import oags_pkg::*;
    import steer_regs_pkg::*;

    localparam int CORDIC_STAGES = 16;
    localparam int FRACTION_BITS = 12;
    // Number of random phases, each under its own register setting.
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 238;
    // Cycles the result side refuses data while the request side keeps pushing.
    localparam int HOLD_CYCLES   = 400;
    // Upper bound on how long we wait for outstanding results to drain.
    localparam int DRAIN_LIMIT   = 20000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [79:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;

    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int outstanding;

    // Idling controls shared between the request and result processes. While a
    // "steady" flag is set that side never idles; hold_req asks the result side
    // for one long stall.
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;
    bit hold_req    = 1'b0;

    // Our own copy of the programmed registers, used only to aim the stimulus
    // at the interesting corners (limit edges, arrival edges, goal bearing).
    int goal_x_now = RESET_GOAL_X;
    int goal_y_now = RESET_GOAL_Y;
    int near_now   = RESET_NEAR_LIMIT;
    int tol_now    = RESET_HEADING_TOL;
    int margin_now = RESET_ARRIVE_MARGIN;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    obstacle_avoid_goal_steering_core #(
        .CORDIC_STAGES(CORDIC_STAGES),
        .FRACTION_BITS(FRACTION_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The checker watches both streams and the register port, predicts every
    // result and compares it; it only hands back its counters.
    steering_cmd_check #(
        .CORDIC_STAGES(CORDIC_STAGES),
        .FRACTION_BITS(FRACTION_BITS)
    ) i_cmd_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatch_count(mismatch_count),
        .outstanding   (outstanding)
    );

    // Mostly short gaps, now and then a long one, none while steady.
    function automatic int pick_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] clip16(int v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic logic [15:0] clipu16(int v);
        if (v > 65535) return 16'hffff;
        if (v < 0) return 16'h0000;
        return v[15:0];
    endfunction

    function automatic logic [79:0] pack_request(logic [15:0] left, logic [15:0] right,
                                                 logic [15:0] px, logic [15:0] py,
                                                 logic [15:0] hdg);
        return {hdg, py, px, right, left};
    endfunction

    // Heading that points the robot straight at the goal, plus an offset in LSBs.
    // The block's CORDIC lands within an LSB or two of this, so small offsets
    // straddle the heading tolerance.
    function automatic logic [15:0] aim_heading(logic [15:0] px, logic [15:0] py, int offset);
        real a;
        a = $atan2(real'(goal_y_now - int'($signed(py))), real'(goal_x_now - int'($signed(px))));
        return clip16($rtoi($floor(a * 4096.0 + 0.5)) + offset);
    endfunction

    // Clearance: fully random, right at the near limit, or clear of it.
    function automatic logic [15:0] pick_clearance();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 16'($urandom);
        if (r < 6) return clipu16(near_now + int'($urandom_range(0, 6)) - 3);
        return 16'($urandom_range(near_now, 65535));
    endfunction

    // Pose coordinate: fully random or near the arrival edge (goal - margin).
    function automatic logic [15:0] pick_coord(int goal);
        if ($urandom_range(0, 9) < 6) return 16'($urandom);
        return clip16(goal - margin_now + int'($urandom_range(0, 8)) - 4);
    endfunction

    // One request: present it, hold it until the handshake, then maybe idle.
    task automatic send_request(logic [79:0] d);
        int gap;
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        gap = pick_gap(send_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic stop_requests();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_request();
        logic [15:0] left, right, px, py, hdg;
        int t;
        left  = pick_clearance();
        right = pick_clearance();
        px    = pick_coord(goal_x_now);
        py    = pick_coord(goal_y_now);
        t     = (tol_now > 2000) ? 2000 : tol_now;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: hdg = 16'($urandom);
            9:          hdg = aim_heading(px, py, 0);
            default:    hdg = aim_heading(px, py, int'($urandom_range(0, 2 * t + 6)) - (t + 3));
        endcase
        send_request(pack_request(left, right, px, py, hdg));
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(steer_reg_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * int'(idx));
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(int gx, int gy, int nl, int tol, int mg);
        write_reg(REG_GOAL_X, 32'(gx) & 32'h0000ffff);
        write_reg(REG_GOAL_Y, 32'(gy) & 32'h0000ffff);
        write_reg(REG_NEAR_LIMIT, 32'(nl) & 32'h0000ffff);
        write_reg(REG_HEADING_TOL, 32'(tol) & 32'h00007fff);
        write_reg(REG_ARRIVE_MARGIN, 32'(mg) & 32'h00007fff);
        goal_x_now = gx;
        goal_y_now = gy;
        near_now   = nl;
        tol_now    = tol;
        margin_now = mg;
    endtask

    // Every request yields exactly one result, so once nothing is outstanding
    // the pipeline is empty and registers may be rewritten.
    task automatic wait_drained();
        int waited;
        waited = 0;
        while (outstanding != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    // Directed requests under the reset register values: goal (5.0, -3.5),
    // near limit 0.5, heading tolerance 1 LSB, no arrival margin.
    task automatic send_directed_defaults();
        // Left avoidance: zero clearance, and one LSB under the limit.
        send_request(pack_request(16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_request(pack_request(16'd2047, 16'hffff, 16'h7fff, 16'h8000, 16'h7fff));
        // Right avoidance: left sits exactly on the limit, right under it.
        send_request(pack_request(16'd2048, 16'd2047, 16'd0, 16'd0, 16'd0));
        send_request(pack_request(16'd2048, 16'd0, 16'h8000, 16'h7fff, 16'h8000));
        // Goal on the robot: zero angle and distance, arrived.
        send_request(pack_request(16'd2048, 16'd2048, 16'd20480, 16'hc800, 16'd0));
        // Just short of the goal in x, then in y (4.9998 and -3.5002).
        send_request(pack_request(16'hffff, 16'hffff, 16'd20479, 16'hc800, 16'd0));
        send_request(pack_request(16'hffff, 16'hffff, 16'd20480, 16'hc7ff, 16'd0));
        // Goal behind the robot, both quadrants of the fold, and on the axes.
        send_request(pack_request(16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 16'h8000));
        send_request(pack_request(16'hffff, 16'hffff, 16'h7fff, 16'h8000, 16'h7fff));
        send_request(pack_request(16'hffff, 16'hffff, 16'd20480, 16'h8000, 16'd0));
        send_request(pack_request(16'hffff, 16'hffff, 16'd20480, 16'h7fff, 16'd0));
        send_request(pack_request(16'hffff, 16'hffff, 16'h7fff, 16'hc800, 16'd0));
        send_request(pack_request(16'hffff, 16'hffff, 16'h8000, 16'hc800, 16'd0));
        // Aimed at the goal, so speed is the distance; then just around the
        // heading tolerance.
        send_request(pack_request(16'hffff, 16'hffff, 16'h8000, 16'h7fff,
                                  aim_heading(16'h8000, 16'h7fff, 0)));
        send_request(pack_request(16'h5555, 16'haaaa, 16'd0, 16'd0, aim_heading(16'd0, 16'd0, 0)));
        send_request(pack_request(16'haaaa, 16'h5555, 16'd0, 16'd0, aim_heading(16'd0, 16'd0, 1)));
        send_request(pack_request(16'hffff, 16'hffff, 16'd0, 16'd0, aim_heading(16'd0, 16'd0, -1)));
        send_request(pack_request(16'hffff, 16'hffff, 16'h5555, 16'haaaa, 16'haaaa));
    endtask

    // The result side: random stalls and runs, plus one long hold on request.
    initial begin : result_side
        int stall, run;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            stall = pick_gap(take_steady);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            run = take_steady ? 64 : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
        end
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int gx, gy, nl, tol, mg;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_directed_defaults();
        stop_requests();
        wait_drained();

        // Extreme setting: goal in the far corner, every clearance but the
        // largest triggers avoidance, so the avoidance turns saturate.
        set_config(-32768, 32767, 65535, 0, 0);
        send_request(pack_request(16'hfffe, 16'd0, 16'd0, 16'd0, 16'd0));
        send_request(pack_request(16'hffff, 16'hfffe, 16'h8000, 16'h7fff, 16'd0));
        send_request(pack_request(16'hffff, 16'hffff, 16'h8000, 16'h7fff, 16'd0));
        send_request(pack_request(16'hffff, 16'hffff, 16'h7fff, 16'h7ffe, 16'h8000));
        stop_requests();
        wait_drained();

        // Opposite extreme: avoidance never fires, the heading tolerance is the widest,
        // and so is the arrival margin.
        set_config(32767, -32768, 0, 32767, 32767);
        send_request(pack_request(16'd0, 16'd0, 16'h8000, 16'h7fff, 16'h7fff));
        send_request(pack_request(16'd0, 16'd0, 16'd0, 16'hffff, 16'h8000));
        send_request(pack_request(16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'd0));
        stop_requests();
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            gx = ($urandom_range(0, 2) == 0) ? int'($signed(16'($urandom)))
                                             : int'($urandom_range(0, 16384)) - 8192;
            gy = ($urandom_range(0, 2) == 0) ? int'($signed(16'($urandom)))
                                             : int'($urandom_range(0, 16384)) - 8192;
            case ($urandom_range(0, 3))
                0:       nl = 0;
                1:       nl = $urandom_range(0, 8192);
                2:       nl = $urandom_range(0, 65535);
                default: nl = $urandom_range(1024, 4096);
            endcase
            case ($urandom_range(0, 3))
                0:       tol = $urandom_range(0, 16);
                1:       tol = $urandom_range(100, 4000);
                2:       tol = 32767;
                default: tol = $urandom_range(0, 32767);
            endcase
            mg = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 64))
                                             : int'($urandom_range(0, 32767));
            set_config(gx, gy, nl, tol, mg);

            // Phase 2 fills the block: the result side holds off for a long
            // stretch while requests keep coming back to back.
            if (ph == 2) hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_steady = (ph == 4) || (ph == 2 && k < 120);
                take_steady = (ph == 4);
                send_random_request();
            end
            send_steady = 1'b0;
            take_steady = 1'b0;
            stop_requests();
            wait_drained();
        end

        // Let any stray late result show up before judging.
        repeat (40) @(posedge aclk);
        if (outstanding != 0)
            $display("%0d expected results never arrived", outstanding);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== obstacle_avoid_goal_steering_core.f =====
+incdir+hw/rtl
hw/rtl/oags_pkg.sv
hw/rtl/oags_front.sv
hw/rtl/oags_cell.sv
hw/rtl/oags_back.sv
hw/rtl/obstacle_avoid_goal_steering_core.sv
dv/steer_regs_pkg.sv
dv/steering_cmd_check.sv
dv/tb_obstacle_avoid_goal_steering_core.sv
